@@ hdl/tpq_pkg.sv @@
// Package for the two-level priority queue: sizes, command and status codes,
// entry and neighbour-link types, and the ranking function.
// No dependencies.
package tpq_pkg;

  localparam int DEPTH      = 16;
  localparam int TIME_BITS  = 16;
  localparam int ID_CHARS   = 5;
  localparam int CODE_CHARS = 3;
  localparam int ID_W       = 8 * ID_CHARS;
  localparam int CODE_W     = 8 * CODE_CHARS;
  localparam int WAIT_W     = 16;
  localparam int CNT_W      = 5;
  localparam int TOT_W      = 20;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [CODE_W-1:0]    code;
    logic [TIME_BITS-1:0] tleft;
    logic                 emg;
    logic [WAIT_W-1:0]    waited;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   outr;
  } link_t;

  localparam link_t EDGE_LEFT  = '{entry: '0, valid: 1'b0, outr: 1'b1};
  localparam link_t EDGE_RIGHT = '{entry: '0, valid: 1'b0, outr: 1'b0};

  function automatic logic outranks(input logic s_emg, input logic [TIME_BITS-1:0] s_time,
                                    input logic n_emg, input logic [TIME_BITS-1:0] n_time);
    logic r;
    if (s_emg != n_emg) begin
      r = s_emg;
    end else begin
      r = (s_time < n_time);
    end
    return r;
  endfunction

endpackage

@@ hdl/tpq_cell.sv @@
// One queue cell: holds one entry and its valid flag, compares it with the
// incoming entry and shifts to or from its neighbours. Uses tpq_pkg.
module tpq_cell (
  input  logic           clk,
  input  logic           rst,
  input  tpq_pkg::op_t   op,
  input  tpq_pkg::entry_t new_entry,
  input  tpq_pkg::link_t left,
  input  tpq_pkg::link_t right,
  output tpq_pkg::link_t link
);

  tpq_pkg::entry_t entry;
  tpq_pkg::entry_t entry_next;
  logic            valid;
  logic            valid_next;
  logic            outr;

  always_comb begin
    outr       = valid && tpq_pkg::outranks(entry.emg, entry.tleft,
                                            new_entry.emg, new_entry.tleft);
    entry_next = entry;
    valid_next = valid;
    case (op)
      tpq_pkg::OP_INSERT: begin
        if (!outr) begin
          if (left.outr) begin
            entry_next = new_entry;
            valid_next = 1'b1;
          end else begin
            entry_next = left.entry;
            valid_next = left.valid;
          end
        end
      end
      tpq_pkg::OP_REMOVE: begin
        entry_next = right.entry;
        valid_next = right.valid;
      end
      tpq_pkg::OP_TICK: begin
        if (valid) begin
          if (entry.tleft != '0) begin
            entry_next.tleft = entry.tleft - 1'b1;
          end
          if (entry.waited != '1) begin
            entry_next.waited = entry.waited + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  assign link.entry = entry;
  assign link.valid = valid;
  assign link.outr  = outr;

endmodule

@@ hdl/two_level_priority_queue.sv @@
// Top level of the two-level priority queue: a row of tpq_cell instances,
// running count and total, and the result register. Uses tpq_pkg, tpq_cell.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | cmd, flight_id, airport_code, time_left,
//           |           |                       | is_emergency
//   out     | output    | out_valid / out_stall | status, head_*, entry_count, total_time
//
// Every command is applied at the accepting edge: the whole cell row and the
// output register update together at that edge.
// A new command is taken in the same cycle as the previous result leaves;
// in_stall is high only while a result is held by out_stall.
// Reset empties the queue at once and drops any waiting result.
module two_level_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        cmd,
  input  logic [tpq_pkg::ID_W-1:0]          flight_id,
  input  logic [tpq_pkg::CODE_W-1:0]        airport_code,
  input  logic [tpq_pkg::TIME_BITS-1:0]     time_left,
  input  logic                              is_emergency,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [tpq_pkg::ID_W-1:0]          head_id,
  output logic [tpq_pkg::CODE_W-1:0]        head_code,
  output logic [tpq_pkg::TIME_BITS-1:0]     head_time,
  output logic                              head_emergency,
  output logic [tpq_pkg::WAIT_W-1:0]        head_waited,
  output logic [tpq_pkg::CNT_W-1:0]         entry_count,
  output logic [tpq_pkg::TOT_W-1:0]         total_time
);

  tpq_pkg::link_t  links [tpq_pkg::DEPTH];
  tpq_pkg::link_t  lefts [tpq_pkg::DEPTH];
  tpq_pkg::link_t  rights [tpq_pkg::DEPTH];
  tpq_pkg::entry_t new_entry;
  tpq_pkg::op_t    cmd_op;
  tpq_pkg::op_t    op;
  tpq_pkg::status_t st;
  logic            accept;
  logic            full;
  logic            empty;
  logic [tpq_pkg::DEPTH-1:0] ticking;
  logic [tpq_pkg::CNT_W-1:0] count;
  logic [tpq_pkg::CNT_W-1:0] count_next;
  logic [tpq_pkg::TOT_W-1:0] total;
  logic [tpq_pkg::TOT_W-1:0] total_next;
  logic            popped;

  assign accept = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign full  = (count == tpq_pkg::CNT_W'(tpq_pkg::DEPTH));
  assign empty = (count == '0);
  assign cmd_op = tpq_pkg::op_t'(cmd);

  assign new_entry.id     = flight_id;
  assign new_entry.code   = airport_code;
  assign new_entry.tleft  = time_left;
  assign new_entry.emg    = is_emergency;
  assign new_entry.waited = '0;

  always_comb begin
    op = tpq_pkg::OP_NOP;
    st = tpq_pkg::ST_OK;
    if (accept) begin
      case (cmd_op)
        tpq_pkg::OP_INSERT: begin
          if (full) begin
            st = tpq_pkg::ST_FULL;
          end else begin
            op = tpq_pkg::OP_INSERT;
          end
        end
        tpq_pkg::OP_REMOVE: begin
          if (empty) begin
            st = tpq_pkg::ST_EMPTY;
          end else begin
            op = tpq_pkg::OP_REMOVE;
          end
        end
        tpq_pkg::OP_TICK: op = tpq_pkg::OP_TICK;
        default: op = tpq_pkg::OP_NOP;
      endcase
    end
  end

  for (genvar i = 0; i < tpq_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = tpq_pkg::EDGE_LEFT;
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == tpq_pkg::DEPTH - 1) begin : g_last
      assign rights[i] = tpq_pkg::EDGE_RIGHT;
    end else begin : g_inner
      assign rights[i] = links[i+1];
    end
    assign ticking[i] = links[i].valid && (links[i].entry.tleft != '0);

    tpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .new_entry (new_entry),
      .left      (lefts[i]),
      .right     (rights[i]),
      .link      (links[i])
    );
  end

  assign popped = (op == tpq_pkg::OP_REMOVE);

  always_comb begin
    count_next = count;
    total_next = total;
    case (op)
      tpq_pkg::OP_INSERT: begin
        count_next = count + 1'b1;
        total_next = total + tpq_pkg::TOT_W'(time_left);
      end
      tpq_pkg::OP_REMOVE: begin
        count_next = count - 1'b1;
        total_next = total - tpq_pkg::TOT_W'(links[0].entry.tleft);
      end
      tpq_pkg::OP_TICK: begin
        total_next = total - tpq_pkg::TOT_W'($countones(ticking));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      total <= total_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= st;
      head_id        <= popped ? links[0].entry.id     : '0;
      head_code      <= popped ? links[0].entry.code   : '0;
      head_time      <= popped ? links[0].entry.tleft  : '0;
      head_emergency <= popped ? links[0].entry.emg    : 1'b0;
      head_waited    <= popped ? links[0].entry.waited : '0;
      entry_count    <= count_next;
      total_time     <= total_next;
    end
  end

endmodule

@@ hdl/tpq_checker.sv @@
// Port-level checks for the two-level priority queue, bound to the top level.
// Uses tpq_pkg.
module tpq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [tpq_pkg::ID_W-1:0]      head_id,
  input logic [tpq_pkg::WAIT_W-1:0]    head_waited,
  input logic [tpq_pkg::CNT_W-1:0]     entry_count
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= tpq_pkg::CNT_W'(tpq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == tpq_pkg::ST_FULL) |-> entry_count == tpq_pkg::CNT_W'(tpq_pkg::DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == tpq_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with entries held");

  a_no_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != tpq_pkg::ST_OK) |-> (head_id == '0 && head_waited == '0))
    else $error("head reported on failed transaction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind two_level_priority_queue tpq_checker u_tpq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .head_id     (head_id),
  .head_waited (head_waited),
  .entry_count (entry_count)
);

@@ bench/two_level_priority_queue_tb.sv @@
// Self-checking testbench for two_level_priority_queue: directed table, short aging
// run and random command phases, checked against an in-bench queue predictor.
// Depends on tpq_pkg and the two_level_priority_queue RTL.
module two_level_priority_queue_tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 250;
  localparam int PHASE_ITEMS  = 420;
  localparam int AGING_TICKS  = 24;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    tpq_pkg::op_t                  op;
    logic [tpq_pkg::ID_W-1:0]      id;
    logic [tpq_pkg::CODE_W-1:0]    code;
    logic [tpq_pkg::TIME_BITS-1:0] tleft;
    logic                          emg;
  } cmd_item_t;

  typedef struct packed {
    tpq_pkg::status_t          status;
    tpq_pkg::entry_t           head;
    logic [tpq_pkg::CNT_W-1:0] count;
    logic [tpq_pkg::TOT_W-1:0] total;
  } queue_result_t;

  typedef struct {
    cmd_item_t     item;
    bit            typed;
    queue_result_t want;
  } directed_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    cmd = '0;
  logic [tpq_pkg::ID_W-1:0]      flight_id = '0;
  logic [tpq_pkg::CODE_W-1:0]    airport_code = '0;
  logic [tpq_pkg::TIME_BITS-1:0] time_left = '0;
  logic                          is_emergency = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    status;
  logic [tpq_pkg::ID_W-1:0]      head_id;
  logic [tpq_pkg::CODE_W-1:0]    head_code;
  logic [tpq_pkg::TIME_BITS-1:0] head_time;
  logic                          head_emergency;
  logic [tpq_pkg::WAIT_W-1:0]    head_waited;
  logic [tpq_pkg::CNT_W-1:0]     entry_count;
  logic [tpq_pkg::TOT_W-1:0]     total_time;

  tpq_pkg::entry_t held_slot [tpq_pkg::DEPTH];
  int              held_count = 0;
  queue_result_t   pending_results [$];
  directed_row_t   plan [$];

  int unsigned faults = 0;
  int unsigned cycle_count = 0;
  int unsigned n_cmds = 0, n_insert = 0, n_full = 0, n_remove = 0, n_empty = 0, n_tick = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0, hold_ack = 0, hold_left = 0;

  two_level_priority_queue DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic ranks_ahead(tpq_pkg::entry_t s, logic emg,
                                       logic [tpq_pkg::TIME_BITS-1:0] t);
    if (s.emg && !emg) return 1'b1;
    if (!s.emg && emg) return 1'b0;
    return s.tleft < t;
  endfunction

  function automatic queue_result_t queue_step(cmd_item_t it);
    queue_result_t   r;
    tpq_pkg::entry_t e;
    int              p;
    int              sum;
    r = '0;
    r.status = tpq_pkg::ST_OK;
    sum = 0;
    n_cmds++;
    case (it.op)
      tpq_pkg::OP_INSERT: begin
        n_insert++;
        if (held_count >= tpq_pkg::DEPTH) begin
          r.status = tpq_pkg::ST_FULL;
          n_full++;
        end else begin
          p = 0;
          while (p < held_count && ranks_ahead(held_slot[p], it.emg, it.tleft)) p++;
          for (int i = held_count; i > p; i--) held_slot[i] = held_slot[i-1];
          e.id = it.id;
          e.code = it.code;
          e.tleft = it.tleft;
          e.emg = it.emg;
          e.waited = '0;
          held_slot[p] = e;
          held_count++;
        end
      end
      tpq_pkg::OP_REMOVE: begin
        n_remove++;
        if (held_count == 0) begin
          r.status = tpq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.head = held_slot[0];
          for (int i = 0; i + 1 < held_count; i++) held_slot[i] = held_slot[i+1];
          held_count--;
        end
      end
      tpq_pkg::OP_TICK: begin
        n_tick++;
        for (int i = 0; i < held_count; i++) begin
          if (held_slot[i].tleft != '0) held_slot[i].tleft--;
          if (held_slot[i].waited != '1) held_slot[i].waited++;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < held_count; i++) sum += held_slot[i].tleft;
    r.count = tpq_pkg::CNT_W'(held_count);
    r.total = tpq_pkg::TOT_W'(sum);
    return r;
  endfunction

  function automatic cmd_item_t mk(tpq_pkg::op_t op, logic [tpq_pkg::ID_W-1:0] id,
                                   logic [tpq_pkg::CODE_W-1:0] code,
                                   logic [tpq_pkg::TIME_BITS-1:0] t, logic emg);
    cmd_item_t c;
    c.op = op;
    c.id = id;
    c.code = code;
    c.tleft = t;
    c.emg = emg;
    return c;
  endfunction

  function automatic queue_result_t quiet(tpq_pkg::status_t s, int cnt, int tot);
    queue_result_t r;
    r = '0;
    r.status = s;
    r.count = tpq_pkg::CNT_W'(cnt);
    r.total = tpq_pkg::TOT_W'(tot);
    return r;
  endfunction

  function automatic cmd_item_t random_command(bit filling);
    cmd_item_t   c;
    int unsigned pick;
    int unsigned mode;
    pick = $urandom_range(99);
    if (pick < 5) c.op = tpq_pkg::OP_NOP;
    else if (pick < 20) c.op = tpq_pkg::OP_TICK;
    else if (pick < (filling ? 80 : 45)) c.op = tpq_pkg::OP_INSERT;
    else c.op = tpq_pkg::OP_REMOVE;
    c.id = tpq_pkg::ID_W'({$urandom(), $urandom()});
    c.code = tpq_pkg::CODE_W'($urandom());
    mode = $urandom_range(9);
    if (mode < 4) c.tleft = tpq_pkg::TIME_BITS'($urandom_range(7));
    else if (mode == 4) c.tleft = $urandom_range(1) ? '1 : '0;
    else c.tleft = tpq_pkg::TIME_BITS'($urandom());
    c.emg = ($urandom_range(9) < 3);
    return c;
  endfunction

  task automatic issue(cmd_item_t it, bit typed, queue_result_t want);
    int unsigned   gap;
    queue_result_t r;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.op;
    flight_id <= it.id;
    airport_code <= it.code;
    time_left <= it.tleft;
    is_emergency <= it.emg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = queue_step(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= PRINT_CAP)
        $display("%0t tb: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic compare_result();
    queue_result_t want;
    if (pending_results.size() == 0) begin
      faults++;
      if (faults <= PRINT_CAP)
        $display("%0t tb: result with nothing expected, status %0d", $time, status);
    end else begin
      want = pending_results.pop_front();
      check_field("status", want.status, status);
      check_field("head_id", want.head.id, head_id);
      check_field("head_code", want.head.code, head_code);
      check_field("head_time", want.head.tleft, head_time);
      check_field("head_emergency", want.head.emg, head_emergency);
      check_field("head_waited", want.head.waited, head_waited);
      check_field("entry_count", want.count, entry_count);
      check_field("total_time", want.total, total_time);
    end
  endtask

  // sample on the old values, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) compare_result();
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t tb: timed out after %0d cycles", $time, cycle_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned gap_tab [4];
    int unsigned stall_tab [4];
    gap_tab = '{0, 79, 0, 25};
    stall_tab = '{0, 0, 79, 25};

    plan.push_back('{mk(tpq_pkg::OP_REMOVE, '0, '0, '0, 1'b0), 1'b1,
                     quiet(tpq_pkg::ST_EMPTY, 0, 0)});
    plan.push_back('{mk(tpq_pkg::OP_TICK, '0, '0, '0, 1'b0), 1'b1,
                     quiet(tpq_pkg::ST_OK, 0, 0)});
    plan.push_back('{mk(tpq_pkg::OP_NOP, '1, '1, '1, 1'b1), 1'b1,
                     quiet(tpq_pkg::ST_OK, 0, 0)});
    plan.push_back('{mk(tpq_pkg::OP_INSERT, '1, '1, '1, 1'b0), 1'b1,
                     quiet(tpq_pkg::ST_OK, 1, 65535)});
    plan.push_back('{mk(tpq_pkg::OP_INSERT, '0, '0, '0, 1'b1), 1'b1,
                     quiet(tpq_pkg::ST_OK, 2, 65535)});
    // tie among emergencies: newer goes first
    plan.push_back('{mk(tpq_pkg::OP_INSERT, 40'h1, 24'h1, '0, 1'b1), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_TICK, '0, '0, '0, 1'b0), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_REMOVE, '0, '0, '0, 1'b0), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_INSERT, 40'h2, 24'h2, '1, 1'b0), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_INSERT, 40'h3, 24'h3, 16'hfffe, 1'b0), 1'b0, '0});
    for (int k = 0; k < 12; k++)
      plan.push_back('{mk(tpq_pkg::OP_INSERT, tpq_pkg::ID_W'(40'h10 + k),
                          tpq_pkg::CODE_W'(24'ha5a5a5 ^ k),
                          tpq_pkg::TIME_BITS'(k * 5461), k[0]), 1'b0, '0});
    // queue full: refuse
    plan.push_back('{mk(tpq_pkg::OP_INSERT, 40'h55, 24'h55, '0, 1'b1), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_REMOVE, '0, '0, '0, 1'b0), 1'b0, '0});
    plan.push_back('{mk(tpq_pkg::OP_TICK, '0, '0, '0, 1'b0), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].item, plan[i].typed, plan[i].want);

    // age a full queue so that the small times stop at zero
    issue(mk(tpq_pkg::OP_INSERT, 40'hfe_dcba_9876, 24'h123456, '1, 1'b1), 1'b0, '0);
    repeat (AGING_TICKS) issue(mk(tpq_pkg::OP_TICK, '0, '0, '0, 1'b0), 1'b0, '0);
    repeat (tpq_pkg::DEPTH) issue(mk(tpq_pkg::OP_REMOVE, '0, '0, '0, 1'b0), 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_tab[ph];
      stall_pct <= stall_tab[ph];
      for (int k = 0; k < PHASE_ITEMS; k++)
        issue(random_command(((k / 40) % 2) == 0), 1'b0, '0);
      if (ph == 0) begin
        // hold the output off while commands keep arriving
        hold_req <= hold_req + 1;
        repeat (40) issue(random_command(1'b1), 1'b0, '0);
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("tb: %0d commands: %0d inserts (%0d refused as full), %0d removes (%0d on empty),",
             n_cmds, n_insert, n_full, n_remove, n_empty);
    $display("tb: %0d ticks incl. aging of a full queue, with idle, stall and hold-off phases",
             n_tick);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
